[sv/fbfpa_pkg.sv]
// Shared constants and codes for the first/best fit partition allocator.
`default_nettype none
package fbfpa_pkg;

  // Item field widths
  localparam int unsigned MODE_W       = 1;
  localparam int unsigned IDX_FIELD_W  = 4;
  localparam int unsigned SIZE_FIELD_W = 16;

  // Configuration port
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 5;

  localparam logic [CFG_INDEX_W-1:0] REG_FIT_POLICY  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_COUNT = 1'd1;

  localparam logic [CFG_DATA_W-1:0] BLOCK_COUNT_RST = 5'd16;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_LOAD  = 1'b0;
  localparam logic [MODE_W-1:0] MODE_ALLOC = 1'b1;

  // Fit policies
  localparam logic POLICY_FIRST = 1'b0;
  localparam logic POLICY_BEST  = 1'b1;

  // Parameter defaults
  localparam int unsigned BLOCKS_DEF    = 16;
  localparam int unsigned SIZE_BITS_DEF = 16;

endpackage
`default_nettype wire

[sv/fbfpa_if.sv]
// Valid/ready channel interfaces for allocator requests and results.
`default_nettype none
interface fbfpa_in_if;
  import fbfpa_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [MODE_W-1:0]       mode;
  logic [IDX_FIELD_W-1:0]  block_index;
  logic [SIZE_FIELD_W-1:0] size_kb;

  modport source (output valid, mode, block_index, size_kb, input ready);
  modport sink   (input valid, mode, block_index, size_kb, output ready);
endinterface

interface fbfpa_out_if;
  import fbfpa_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    granted;
  logic [IDX_FIELD_W-1:0]  chosen_block;
  logic [SIZE_FIELD_W-1:0] remaining_kb;

  modport source (output valid, granted, chosen_block, remaining_kb, input ready);
  modport sink   (input valid, granted, chosen_block, remaining_kb, output ready);
endinterface
`default_nettype wire

[sv/first_best_fit_partition_allocator.sv]
// Load request: table entry written at the accept edge if block_index < BLOCKS, no result.
// Alloc request: N = min(block_count, BLOCKS) entries, one read and compared per cycle;
//   the result is loaded once the result register is free, then the sequencer goes idle.
//   Requests are taken whenever the sequencer is idle, even while a result waits.
// Reset (rst, synchronous): fit_policy = first fit, block_count = 16, no result
//   pending; the free-size table is not cleared and must be loaded before use.
`default_nettype none
module first_best_fit_partition_allocator #(
  parameter int unsigned BLOCKS    = fbfpa_pkg::BLOCKS_DEF,
  parameter int unsigned SIZE_BITS = fbfpa_pkg::SIZE_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [fbfpa_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [fbfpa_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  fbfpa_in_if.sink                                req,
  fbfpa_out_if.source                             rsp
);
  import fbfpa_pkg::*;

  localparam int unsigned IDX_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int unsigned CNT_W = $clog2(BLOCKS + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]            state;
  logic                  fit_policy;
  logic [CFG_DATA_W-1:0] block_count;

  logic [SIZE_BITS-1:0]  mem [BLOCKS];
  logic [SIZE_BITS-1:0]  rd_data;

  logic [SIZE_BITS-1:0]  req_size;
  logic [CNT_W-1:0]      used;
  logic [CNT_W-1:0]      iss;
  logic                  pend;
  logic [IDX_W-1:0]      pend_idx;
  logic                  found;
  logic [IDX_W-1:0]      pick;
  logic [SIZE_BITS-1:0]  best_size;
  logic [SIZE_BITS-1:0]  rem;

  logic                    rsp_valid;
  logic                    rsp_granted;
  logic [IDX_FIELD_W-1:0]  rsp_chosen;
  logic [SIZE_FIELD_W-1:0] rsp_remaining;

  logic                  accept;
  logic [31:0]           size_wide;
  logic [31:0]           idx_wide;
  logic [31:0]           bc_wide;
  logic [31:0]           used_wide;
  logic                  load_hit;
  logic                  issue;
  logic                  take;
  logic [SIZE_BITS-1:0]  diff;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [SIZE_BITS-1:0]  mem_wdata;
  logic [31:0]           rem_wide;
  logic [31:0]           pick_wide;
  logic                  out_free;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  assign size_wide = 32'(req.size_kb);
  assign idx_wide  = 32'(req.block_index);
  assign bc_wide   = 32'(block_count);
  assign used_wide = (bc_wide > BLOCKS) ? BLOCKS : bc_wide;
  assign load_hit  = idx_wide < BLOCKS;

  assign issue = (state == S_SCAN) && (iss < used);

  // Shared compare unit: covers the request, and beats the current pick under best fit.
  assign take = pend && (rd_data >= req_size) &&
                (!found || ((fit_policy == POLICY_BEST) && (rd_data < best_size)));

  assign diff = best_size - req_size;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_wide[IDX_W-1:0];
    mem_wdata = size_wide[SIZE_BITS-1:0];
    if (state == S_WRITE) begin
      mem_we    = found;
      mem_waddr = pick;
      mem_wdata = diff;
    end else if (accept && (req.mode == MODE_LOAD) && load_hit) begin
      mem_we = 1'b1;
    end
  end

  // Free-size table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rd_data <= mem[iss[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy  <= POLICY_FIRST;
      block_count <= BLOCK_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIT_POLICY:  fit_policy  <= cfg_wdata[0];
        REG_BLOCK_COUNT: block_count <= cfg_wdata;
      endcase
    end
  end

  assign rem_wide  = 32'(rem);
  assign pick_wide = 32'(pick);
  assign out_free  = !rsp_valid || rsp.ready;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pend      <= 1'b0;
      found     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // in S_DONE the result register is reloaded below instead
      if (rsp_valid && rsp.ready && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && (req.mode == MODE_ALLOC)) begin
            req_size <= size_wide[SIZE_BITS-1:0];
            used     <= used_wide[CNT_W-1:0];
            iss      <= '0;
            pend     <= 1'b0;
            found    <= 1'b0;
            state    <= (used_wide == 32'd0) ? S_DONE : S_SCAN;
          end
        end
        S_SCAN: begin
          pend     <= issue;
          pend_idx <= iss[IDX_W-1:0];
          if (issue) begin
            iss <= iss + 1'b1;
          end
          if (take) begin
            found     <= 1'b1;
            pick      <= pend_idx;
            best_size <= rd_data;
          end
          // last compare happens in this cycle
          if (!issue && pend) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          rem   <= diff;
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            rsp_valid     <= 1'b1;
            rsp_granted   <= found;
            rsp_chosen    <= found ? pick_wide[IDX_FIELD_W-1:0] : '0;
            rsp_remaining <= found ? rem_wide[SIZE_FIELD_W-1:0] : '0;
            state         <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.granted      = rsp_granted;
  assign rsp.chosen_block = rsp_chosen;
  assign rsp.remaining_kb = rsp_remaining;

  // Assertions
  a_not_granted_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.granted) |-> (rsp.chosen_block == '0 && rsp.remaining_kb == '0))
    else $error("non-granted result carries nonzero fields");

  a_pick_covers: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN || state == S_WRITE) && found) |-> (best_size >= req_size))
    else $error("picked block does not cover the request");

  a_pick_in_use: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE && found) |-> (CNT_W'(pick) < used))
    else $error("picked block outside the blocks in use");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (iss <= used))
    else $error("scan counter ran past block count");

endmodule
`default_nettype wire
